@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while reset is low
`define CHK_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define CHK_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/mcpkey_pkg.sv @@
// types, constants and character tables for the authentication key extractor
package mcpkey_pkg;

   // default depth of the key buffer
   localparam int KEY_MAX_DEF = 63;
   // width of the key length field on the result channel
   localparam int KEY_LEN_W = 6;

   // prefix and key name lengths
   localparam logic [4:0] MCP_LEN  = 5'd3;
   localparam logic [4:0] INIT_LEN = 5'd7;
   localparam logic [4:0] CAN_LEN  = 5'd21;
   localparam logic [4:0] NAME_LEN = 5'd18;
   localparam logic [4:0] NAME_SAT = 5'd19;

   // special characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   // line parser phases
   typedef enum logic [3:0] {
      PH_PREFIX,
      PH_NOTINIT,
      PH_GAP,
      PH_KEY,
      PH_AFTERCOLON,
      PH_VALSP,
      PH_CAPTURE,
      PH_SIMPLE,
      PH_QUOTED,
      PH_ESC,
      PH_DONE
   } phase_type;

   // controller states
   typedef enum logic [1:0] {
      CT_RECV,
      CT_FETCH,
      CT_EMIT
   } ctrl_state_type;

   // line classification
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_OTHER,
      KIND_INIT,
      KIND_CAN
   } line_kind_type;

   // closing status codes
   typedef enum logic [2:0] {
      ST_FOUND,
      ST_NOT_INIT,
      ST_NO_KEY,
      ST_NO_COLON,
      ST_OPEN_QUOTE
   } parse_status_type;

   // commands from controller to datapath
   typedef struct packed {
      logic take;     // input beat accepted
      logic fetch;    // read the next key byte
      logic advance;  // key byte beat taken, step to the next one
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic at_status;  // the next result is the closing status beat
   } dp_stat_type;

   // ascii lower case
   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   // "#$#mcp-negotiate-can "
   function automatic logic [7:0] can_char(input logic [4:0] p);
      logic [7:0] r;
      case (p)
         5'd0:    r = 8'h23;
         5'd1:    r = 8'h24;
         5'd2:    r = 8'h23;
         5'd3:    r = 8'h6D;
         5'd4:    r = 8'h63;
         5'd5:    r = 8'h70;
         5'd6:    r = 8'h2D;
         5'd7:    r = 8'h6E;
         5'd8:    r = 8'h65;
         5'd9:    r = 8'h67;
         5'd10:   r = 8'h6F;
         5'd11:   r = 8'h74;
         5'd12:   r = 8'h69;
         5'd13:   r = 8'h61;
         5'd14:   r = 8'h74;
         5'd15:   r = 8'h65;
         5'd16:   r = 8'h2D;
         5'd17:   r = 8'h63;
         5'd18:   r = 8'h61;
         5'd19:   r = 8'h6E;
         5'd20:   r = 8'h20;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // "#$#mcp " shares its first six characters with the negotiate prefix
   function automatic logic [7:0] init_char(input logic [4:0] p);
      return (p == 5'd6) ? CH_SPACE : can_char(p);
   endfunction

   // "authentication-key"
   function automatic logic [7:0] name_char(input logic [4:0] p);
      logic [7:0] r;
      case (p)
         5'd0:    r = 8'h61;
         5'd1:    r = 8'h75;
         5'd2:    r = 8'h74;
         5'd3:    r = 8'h68;
         5'd4:    r = 8'h65;
         5'd5:    r = 8'h6E;
         5'd6:    r = 8'h74;
         5'd7:    r = 8'h69;
         5'd8:    r = 8'h63;
         5'd9:    r = 8'h61;
         5'd10:   r = 8'h74;
         5'd11:   r = 8'h69;
         5'd12:   r = 8'h6F;
         5'd13:   r = 8'h6E;
         5'd14:   r = 8'h2D;
         5'd15:   r = 8'h6B;
         5'd16:   r = 8'h65;
         5'd17:   r = 8'h79;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

@@ src/mcpkey_ctrl.sv @@
// controller: receive bytes, then fetch and hand out key beats and the status beat
module mcpkey_ctrl
   import mcpkey_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_line_last,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CT_RECV;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CT_RECV: begin
            if (req_valid && req_line_last) begin
               state_in = CT_FETCH;
            end
         end
         CT_FETCH: begin
            state_in = CT_EMIT;
         end
         CT_EMIT: begin
            if (rsp_ready) begin
               state_in = stat.at_status ? CT_RECV : CT_FETCH;
            end
         end
         default: begin
            state_in = CT_RECV;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.take    = 1'b0;
      cmd.fetch   = 1'b0;
      cmd.advance = 1'b0;
      case (state_ff)
         CT_RECV: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         CT_FETCH: begin
            cmd.fetch = 1'b1;
         end
         CT_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready && !stat.at_status;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ src/mcpkey_dp.sv @@
// datapath: line parser, key buffer and line summary
module mcpkey_dp
   import mcpkey_pkg::*;
#(
   parameter int KeyMax = KEY_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   input  logic [7:0]           req_line_byte,
   input  logic                 req_line_last,
   output logic                 rsp_is_status,
   output logic [7:0]           rsp_key_byte,
   output logic                 rsp_run_last,
   output logic [1:0]           rsp_line_kind,
   output logic                 rsp_key_found,
   output logic [KEY_LEN_W-1:0] rsp_key_length,
   output logic [2:0]           rsp_parse_status,
   output logic                 rsp_key_truncated
);

   localparam int CW = $clog2(KeyMax + 1);
   localparam int AW = (KeyMax > 1) ? $clog2(KeyMax) : 1;
   localparam logic [CW-1:0] KEY_MAX_C = CW'(KeyMax);

   // parser state
   phase_type        phase_ff, phase_in;
   logic [4:0]       pos_ff, pos_in;
   logic             iok_ff, iok_in;
   logic             cok_ff, cok_in;
   logic             mok_ff, mok_in;
   logic             knm_ff, knm_in;
   logic [4:0]       koff_ff, koff_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   parse_status_type oc_ff, oc_in;
   logic             closed_ff, closed_in;
   logic             fq_ff, fq_in;
   logic             lq_ff, lq_in;

   // line summary and emission
   line_kind_type    kind_ff, kind_in;
   parse_status_type stat_ff;
   logic             trunc_ff;
   logic [CW-1:0]    len_ff, len_in;
   logic             start_ff, start_in;
   logic [CW-1:0]    k_ff;

   // key buffer
   logic [7:0]       key_mem [KeyMax];
   logic [7:0]       rd_data_ff;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [CW-1:0]    rd_addr;

   // step helpers
   logic       key_step;
   logic       begin_val;
   logic       store;
   logic [7:0] c;
   logic [7:0] lc;

   assign c  = req_line_byte;
   assign lc = to_lower(req_line_byte);

   // one byte through the parser
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      iok_in    = iok_ff;
      cok_in    = cok_ff;
      mok_in    = mok_ff;
      knm_in    = knm_ff;
      koff_in   = koff_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      oc_in     = oc_ff;
      closed_in = closed_ff;
      fq_in     = fq_ff;
      lq_in     = lq_ff;
      key_step  = 1'b0;
      begin_val = 1'b0;
      store     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = cnt_ff[AW-1:0];

      if (!closed_ff && c != CH_NUL) begin
         // value and key scanning
         case (phase_ff)
            PH_GAP: begin
               if (c != CH_SPACE) begin
                  phase_in = PH_KEY;
                  knm_in   = 1'b1;
                  koff_in  = 5'd0;
                  key_step = 1'b1;
               end
            end
            PH_KEY: begin
               key_step = 1'b1;
            end
            PH_AFTERCOLON: begin
               if (c == CH_SPACE) begin
                  phase_in = PH_VALSP;
               end else begin
                  knm_in    = 1'b0;
                  begin_val = 1'b1;
               end
            end
            PH_VALSP: begin
               begin_val = (c != CH_SPACE);
            end
            PH_CAPTURE: begin
               if (c == CH_SPACE) begin
                  oc_in    = ST_FOUND;
                  phase_in = PH_DONE;
               end else begin
                  store = 1'b1;
               end
            end
            PH_SIMPLE: begin
               if (c == CH_SPACE) begin
                  phase_in = PH_GAP;
               end
            end
            PH_QUOTED: begin
               if (c == CH_QUOTE) begin
                  phase_in = PH_GAP;
               end else if (c == CH_BSLASH) begin
                  phase_in = PH_ESC;
               end
            end
            PH_ESC: begin
               phase_in = PH_QUOTED;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase

         // key name characters
         if (key_step) begin
            if (c == CH_COLON) begin
               knm_in   = knm_in && (koff_in == NAME_LEN);
               phase_in = PH_AFTERCOLON;
            end else if (c == CH_SPACE) begin
               oc_in    = ST_NO_COLON;
               phase_in = PH_DONE;
            end else begin
               if (koff_in >= NAME_LEN || lc != name_char(koff_in)) begin
                  knm_in = 1'b0;
               end
               if (koff_in < NAME_SAT) begin
                  koff_in = koff_in + 5'd1;
               end
            end
         end

         // first character of a value
         if (begin_val) begin
            if (knm_in) begin
               phase_in = PH_CAPTURE;
               store    = 1'b1;
            end else if (c == CH_QUOTE) begin
               phase_in = PH_QUOTED;
            end else begin
               phase_in = PH_SIMPLE;
            end
         end

         // key buffer write
         if (store) begin
            if (cnt_ff < KEY_MAX_C) begin
               wr_en = 1'b1;
               if (cnt_ff == '0) begin
                  fq_in = (c == CH_QUOTE);
               end
               lq_in  = (c == CH_QUOTE);
               cnt_in = cnt_ff + CW'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end

         // prefix comparison
         if (pos_ff < CAN_LEN) begin
            if (pos_ff < INIT_LEN && lc != init_char(pos_ff)) begin
               iok_in = 1'b0;
            end
            if (lc != can_char(pos_ff)) begin
               cok_in = 1'b0;
            end
            if (pos_ff < MCP_LEN && c != init_char(pos_ff)) begin
               mok_in = 1'b0;
            end
            pos_in = pos_ff + 5'd1;
            if (phase_in == PH_PREFIX && pos_in == INIT_LEN) begin
               phase_in = iok_in ? PH_GAP : PH_NOTINIT;
            end
         end
      end

      // end of line text
      if (!closed_ff && (c == CH_NUL || req_line_last)) begin
         case (phase_in)
            PH_PREFIX, PH_NOTINIT: oc_in = ST_NOT_INIT;
            PH_KEY:                oc_in = ST_NO_COLON;
            PH_VALSP:              oc_in = knm_in ? ST_FOUND : ST_NO_KEY;
            PH_CAPTURE:            oc_in = ST_FOUND;
            PH_QUOTED, PH_ESC:     oc_in = ST_OPEN_QUOTE;
            PH_DONE:               oc_in = oc_in;
            default:               oc_in = ST_NO_KEY;
         endcase
         phase_in  = PH_DONE;
         closed_in = 1'b1;
      end
   end

   // line summary at the last byte
   always_comb begin
      if (pos_in >= INIT_LEN && iok_in) begin
         kind_in = KIND_INIT;
      end else if (pos_in >= CAN_LEN && cok_in) begin
         kind_in = KIND_CAN;
      end else if (pos_in >= MCP_LEN && mok_in) begin
         kind_in = KIND_OTHER;
      end else begin
         kind_in = KIND_NONE;
      end
      start_in = 1'b0;
      len_in   = (oc_in == ST_FOUND) ? cnt_in : '0;
      if (oc_in == ST_FOUND && !ovf_in && cnt_in > CW'(1) && fq_in && lq_in) begin
         start_in = 1'b1;
         len_in   = cnt_in - CW'(2);
      end
   end

   // parser registers, cleared again after each line
   always_ff @(posedge clock) begin
      if (reset || (cmd.take && req_line_last)) begin
         phase_ff  <= PH_PREFIX;
         pos_ff    <= '0;
         iok_ff    <= 1'b1;
         cok_ff    <= 1'b1;
         mok_ff    <= 1'b1;
         knm_ff    <= 1'b1;
         koff_ff   <= '0;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
         oc_ff     <= ST_FOUND;
         closed_ff <= 1'b0;
      end else if (cmd.take) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         iok_ff    <= iok_in;
         cok_ff    <= cok_in;
         mok_ff    <= mok_in;
         knm_ff    <= knm_in;
         koff_ff   <= koff_in;
         cnt_ff    <= cnt_in;
         ovf_ff    <= ovf_in;
         oc_ff     <= oc_in;
         closed_ff <= closed_in;
      end
   end

   // summary and emission counter
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         fq_ff <= fq_in;
         lq_ff <= lq_in;
      end
      if (cmd.take && req_line_last) begin
         kind_ff  <= kind_in;
         stat_ff  <= oc_in;
         trunc_ff <= ovf_in;
         len_ff   <= len_in;
         start_ff <= start_in;
         k_ff     <= '0;
      end else if (cmd.advance) begin
         k_ff <= k_ff + CW'(1);
      end
   end

   assign stat.at_status = (k_ff == len_ff);
   assign rd_addr        = CW'(start_ff) + k_ff;

   // key buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.take && wr_en) begin
         key_mem[wr_addr] <= c;
      end
      if (cmd.fetch && !stat.at_status) begin
         rd_data_ff <= key_mem[rd_addr[AW-1:0]];
      end
   end

   // result beat
   assign rsp_is_status     = stat.at_status;
   assign rsp_key_byte      = stat.at_status ? 8'h00 : rd_data_ff;
   assign rsp_run_last      = stat.at_status;
   assign rsp_line_kind     = kind_ff;
   assign rsp_key_found     = (stat_ff == ST_FOUND);
   assign rsp_key_length    = KEY_LEN_W'(len_ff);
   assign rsp_parse_status  = stat_ff;
   assign rsp_key_truncated = trunc_ff;

endmodule

@@ src/mcp_auth_key_extractor.sv @@
// top level of the authentication key extractor
//
// Input channel req_*: one line byte per beat, req_line_last on the final byte.
// Bytes are taken one per cycle; the parser keeps the line kind, the parse state
// and the authentication-key value (up to KeyMax bytes) in its key buffer.
// Result channel rsp_*: after the last byte of a line the block sends the key
// bytes, quotes stripped, then one status beat with rsp_run_last set. All
// summary fields are the same on every beat of a run.
// Sequencing: the last byte taken moves the controller from CT_RECV to CT_FETCH
// and then to CT_EMIT. Every result beat, the status beat included, passes
// through CT_FETCH (a key buffer read, for key bytes only) and then CT_EMIT
// (one beat out). req_ready is low while a line's results drain.
// Reset (synchronous) drops any line in progress and any pending results;
// the block then waits for the first byte of a new line.
// A stalled receiver holds the current beat stable, and no input is taken
// until the status beat has gone.
module mcp_auth_key_extractor
   import mcpkey_pkg::*;
#(
   parameter int KeyMax = KEY_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_line_byte,
   input  logic                 req_line_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_is_status,
   output logic [7:0]           rsp_key_byte,
   output logic                 rsp_run_last,
   output logic [1:0]           rsp_line_kind,
   output logic                 rsp_key_found,
   output logic [KEY_LEN_W-1:0] rsp_key_length,
   output logic [2:0]           rsp_parse_status,
   output logic                 rsp_key_truncated
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencing
   mcpkey_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_line_last (req_line_last),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   // parsing and key storage
   mcpkey_dp #(
      .KeyMax (KeyMax)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_line_byte     (req_line_byte),
      .req_line_last     (req_line_last),
      .rsp_is_status     (rsp_is_status),
      .rsp_key_byte      (rsp_key_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_line_kind     (rsp_line_kind),
      .rsp_key_found     (rsp_key_found),
      .rsp_key_length    (rsp_key_length),
      .rsp_parse_status  (rsp_parse_status),
      .rsp_key_truncated (rsp_key_truncated)
   );

endmodule

@@ src/mcpkey_checker.sv @@
// port level checks for the authentication key extractor, bound to the top level
`include "assert_macros.svh"

module mcpkey_checker
   import mcpkey_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_is_status,
   input logic [7:0]           rsp_key_byte,
   input logic                 rsp_run_last,
   input logic [1:0]           rsp_line_kind,
   input logic                 rsp_key_found,
   input logic [KEY_LEN_W-1:0] rsp_key_length,
   input logic [2:0]           rsp_parse_status,
   input logic                 rsp_key_truncated
);

   // a stalled result beat holds every field
   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_is_status, rsp_key_byte,
         rsp_run_last, rsp_line_kind, rsp_key_found, rsp_key_length, rsp_parse_status,
         rsp_key_truncated});
   endproperty

   // key found agrees with status code, and key beats only for a found key
   property p_found_code;
      rsp_valid |-> (rsp_key_found == (rsp_parse_status == ST_FOUND)) &&
         (rsp_is_status || rsp_key_found);
   endproperty

   // nothing pending straight after reset
   `CHK_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result beat after reset")

   // a stalled result beat holds
   `CHK_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "stalled result beat changed")

   // input is held off while a line's results drain
   `CHK_ASSERT(a_no_overlap, clock, reset, rsp_valid |-> !req_ready, "input taken during result run")

   // status beat closes the run
   `CHK_ASSERT(a_status_last, clock, reset, rsp_valid |-> (rsp_is_status == rsp_run_last), "run_last not on status beat")

   // found flag and status code agree
   `CHK_ASSERT(a_found_code, clock, reset, p_found_code, "key found flag disagrees with status")

endmodule

bind mcp_auth_key_extractor mcpkey_checker u_mcpkey_checker (.*);
